[hdl/hbbl_pkg.sv]
// Package for the horn burst budget limiter.
// Holds the register map, configuration and result types shared by all modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbbl_pkg;

   // Field widths
   localparam int TimeW  = 32;
   localparam int StepW  = 10;
   localparam int DutyW  = 8;
   localparam int DataW  = 32;
   localparam int AddrW  = 5;
   localparam int IndexW = 3;

   // Reset values of the configuration registers
   localparam logic [TimeW-1:0] BudgetRst   = 32'd30000;
   localparam logic [TimeW-1:0] PeriodRst   = 32'd3600000;
   localparam logic [TimeW-1:0] MaxBurstRst = 32'd5000;
   localparam logic [TimeW-1:0] CooldownRst = 32'd2000;
   localparam logic [StepW-1:0] StepRst     = 10'd10;
   localparam logic [DutyW-1:0] FullRst     = 8'd255;
   localparam logic [DutyW-1:0] ReducedRst  = 8'd120;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [IndexW-1:0] {
      REG_BUDGET    = 3'd0,
      REG_PERIOD    = 3'd1,
      REG_MAX_BURST = 3'd2,
      REG_COOLDOWN  = 3'd3,
      REG_STEP      = 3'd4,
      REG_FULL      = 3'd5,
      REG_REDUCED   = 3'd6
   } reg_index_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [TimeW-1:0] budget_ms;
      logic [TimeW-1:0] budget_period_ms;
      logic [TimeW-1:0] max_burst_ms;
      logic [TimeW-1:0] cooldown_ms;
      logic [StepW-1:0] budget_step;
      logic [DutyW-1:0] full_duty;
      logic [DutyW-1:0] reduced_duty;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [DutyW-1:0] duty;
      logic             burst_active;
      logic             cooldown_active;
      logic             budget_exhausted;
   } res_type;

endpackage

`default_nettype wire

[hdl/hbbl_csr.sv]
// Configuration register file of the horn burst budget limiter.
// APB-style write/read port; depends on hbbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbbl_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [hbbl_pkg::AddrW-1:0]  csr_paddr,
   input  wire logic [hbbl_pkg::DataW-1:0]  csr_pwdata,
   output logic      [hbbl_pkg::DataW-1:0]  csr_prdata,
   output logic                             csr_pready,
   output hbbl_pkg::cfg_type                cfg
);

   hbbl_pkg::cfg_type       cfg_ff;
   logic                    wr_en;
   hbbl_pkg::reg_index_type idx;

   assign csr_pready = 1'b1;
   assign idx        = hbbl_pkg::reg_index_type'(csr_paddr[hbbl_pkg::AddrW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.budget_ms        <= hbbl_pkg::BudgetRst;
         cfg_ff.budget_period_ms <= hbbl_pkg::PeriodRst;
         cfg_ff.max_burst_ms     <= hbbl_pkg::MaxBurstRst;
         cfg_ff.cooldown_ms      <= hbbl_pkg::CooldownRst;
         cfg_ff.budget_step      <= hbbl_pkg::StepRst;
         cfg_ff.full_duty        <= hbbl_pkg::FullRst;
         cfg_ff.reduced_duty     <= hbbl_pkg::ReducedRst;
      end else if (wr_en) begin
         case (idx)
            hbbl_pkg::REG_BUDGET:    cfg_ff.budget_ms        <= csr_pwdata;
            hbbl_pkg::REG_PERIOD:    cfg_ff.budget_period_ms <= csr_pwdata;
            hbbl_pkg::REG_MAX_BURST: cfg_ff.max_burst_ms     <= csr_pwdata;
            hbbl_pkg::REG_COOLDOWN:  cfg_ff.cooldown_ms      <= csr_pwdata;
            hbbl_pkg::REG_STEP:      cfg_ff.budget_step      <= csr_pwdata[hbbl_pkg::StepW-1:0];
            hbbl_pkg::REG_FULL:      cfg_ff.full_duty        <= csr_pwdata[hbbl_pkg::DutyW-1:0];
            hbbl_pkg::REG_REDUCED:   cfg_ff.reduced_duty     <= csr_pwdata[hbbl_pkg::DutyW-1:0];
            default: ;
         endcase
      end
   end

   // Read mux, narrow registers zero-extended
   always_comb begin
      case (idx)
         hbbl_pkg::REG_BUDGET:    csr_prdata = cfg_ff.budget_ms;
         hbbl_pkg::REG_PERIOD:    csr_prdata = cfg_ff.budget_period_ms;
         hbbl_pkg::REG_MAX_BURST: csr_prdata = cfg_ff.max_burst_ms;
         hbbl_pkg::REG_COOLDOWN:  csr_prdata = cfg_ff.cooldown_ms;
         hbbl_pkg::REG_STEP:
            csr_prdata = {{(hbbl_pkg::DataW-hbbl_pkg::StepW){1'b0}}, cfg_ff.budget_step};
         hbbl_pkg::REG_FULL:
            csr_prdata = {{(hbbl_pkg::DataW-hbbl_pkg::DutyW){1'b0}}, cfg_ff.full_duty};
         hbbl_pkg::REG_REDUCED:
            csr_prdata = {{(hbbl_pkg::DataW-hbbl_pkg::DutyW){1'b0}}, cfg_ff.reduced_duty};
         default:                 csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[hdl/hbbl_core.sv]
// Poll evaluation and state registers of the horn burst budget limiter.
// Period, cooldown, burst and budget logic; depends on hbbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbbl_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_en,
   input  wire logic                        pressed,
   input  wire logic [hbbl_pkg::TimeW-1:0]  now_ms,
   input  hbbl_pkg::cfg_type                cfg,
   output hbbl_pkg::res_type                res
);

   localparam int TW = hbbl_pkg::TimeW;

   logic [TW-1:0] used_ff, used_in;
   logic [TW-1:0] period_start_ff, period_start_in;
   logic [TW-1:0] burst_start_ff, burst_start_in;
   logic [TW-1:0] release_ff, release_in;
   logic          in_burst_ff, in_burst_in;
   logic          in_cooldown_ff, in_cooldown_in;

   logic [TW-1:0] used_base;
   logic [TW-1:0] burst_origin;
   logic [TW:0]   used_sum;
   logic          period_hit;
   logic          cooldown_done;
   logic          burst_over;

   // Elapsed-time checks, all modulo 2^32
   assign period_hit    = (now_ms - period_start_ff) >= cfg.budget_period_ms;
   assign cooldown_done = (now_ms - release_ff) >= cfg.cooldown_ms;
   assign used_base     = period_hit ? '0 : used_ff;
   assign burst_origin  = in_burst_ff ? burst_start_ff : now_ms;
   assign burst_over    = (now_ms - burst_origin) >= cfg.max_burst_ms;
   assign used_sum      = {1'b0, used_base}
                        + {{(TW + 1 - hbbl_pkg::StepW){1'b0}}, cfg.budget_step};

   // Next state and duty for one poll
   always_comb begin
      used_in         = used_base;
      period_start_in = period_hit ? now_ms : period_start_ff;
      burst_start_in  = burst_start_ff;
      release_in      = release_ff;
      in_burst_in     = in_burst_ff;
      in_cooldown_in  = in_cooldown_ff;
      res.duty        = '0;

      if (in_cooldown_ff && !cooldown_done) begin
         // still silent
      end else begin
         in_cooldown_in = 1'b0;
         if (pressed) begin
            burst_start_in = burst_origin;
            if (burst_over) begin
               in_burst_in    = 1'b0;
               in_cooldown_in = 1'b1;
               release_in     = now_ms;
            end else begin
               in_burst_in = 1'b1;
               if (used_base < cfg.budget_ms) begin
                  // saturate on carry out
                  used_in  = used_sum[TW] ? '1 : used_sum[TW-1:0];
                  res.duty = cfg.full_duty;
               end else begin
                  res.duty = cfg.reduced_duty;
               end
            end
         end else if (in_burst_ff) begin
            in_burst_in    = 1'b0;
            in_cooldown_in = 1'b1;
            release_in     = now_ms;
         end
      end

      res.burst_active     = in_burst_in;
      res.cooldown_active  = in_cooldown_in;
      res.budget_exhausted = used_in >= cfg.budget_ms;
   end

   // State update, once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff         <= '0;
         period_start_ff <= '0;
         burst_start_ff  <= '0;
         release_ff      <= '0;
         in_burst_ff     <= 1'b0;
         in_cooldown_ff  <= 1'b0;
      end else if (step_en) begin
         used_ff         <= used_in;
         period_start_ff <= period_start_in;
         burst_start_ff  <= burst_start_in;
         release_ff      <= release_in;
         in_burst_ff     <= in_burst_in;
         in_cooldown_ff  <= in_cooldown_in;
      end
   end

   // A burst and a cooldown never overlap
   a_burst_cooldown_excl: assert property (@(posedge clock) disable iff (reset)
      !(in_burst_ff && in_cooldown_ff))
      else $error("burst and cooldown both active");

   // Usage only grows within a period unless it clears
   a_used_monotone: assert property (@(posedge clock) disable iff (reset)
      (step_en && !period_hit) |=> (used_ff >= $past(used_ff)))
      else $error("usage decreased without a period reset");

endmodule

`default_nettype wire

[hdl/horn_burst_budget_limiter.sv]
// Top level of the horn burst budget limiter.
// Input register, hbbl_core evaluation, result register; uses hbbl_csr and hbbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Horn burst budget limiter: each poll (button level plus millisecond
// timestamp) gives one result with the PWM duty and the burst, cooldown and
// budget flags. A poll is taken every cycle while the result side keeps up;
// the poll is evaluated from the input register, and its result is then
// stored in the result register, which holds it on the result channel
// until the result is transferred. The state
// registers in the core are updated when a poll moves from the input register
// into the result register, so back-to-back polls see each other's effect.
// A stalled result holds the result register; the input register still takes
// one further poll before req_stall rises. Configuration registers should be
// written only while no poll is in flight.

module horn_burst_budget_limiter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // poll channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_pressed,
   input  wire logic [hbbl_pkg::TimeW-1:0]  req_now_ms,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [hbbl_pkg::DutyW-1:0]  rsp_duty,
   output logic                             rsp_burst_active,
   output logic                             rsp_cooldown_active,
   output logic                             rsp_budget_exhausted,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [hbbl_pkg::AddrW-1:0]  csr_paddr,
   input  wire logic [hbbl_pkg::DataW-1:0]  csr_pwdata,
   output logic      [hbbl_pkg::DataW-1:0]  csr_prdata,
   output logic                             csr_pready
);

   hbbl_pkg::cfg_type cfg;
   hbbl_pkg::res_type res;
   hbbl_pkg::res_type rsp_ff;

   logic                       in_valid_ff, in_valid_in;
   logic                       in_pressed_ff;
   logic [hbbl_pkg::TimeW-1:0] in_now_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   // Pipeline control
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !out_free);

   hbbl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hbbl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .pressed (in_pressed_ff),
      .now_ms  (in_now_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pressed_ff <= req_pressed;
         in_now_ff     <= req_now_ms;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty             = rsp_ff.duty;
   assign rsp_burst_active     = rsp_ff.burst_active;
   assign rsp_cooldown_active  = rsp_ff.cooldown_active;
   assign rsp_budget_exhausted = rsp_ff.budget_exhausted;

   // A waiting poll is not dropped
   a_in_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("waiting poll lost");

   // A cooldown result is always silent
   a_cooldown_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.cooldown_active) |-> (rsp_ff.duty == '0))
      else $error("non-zero duty during cooldown");

endmodule

`default_nettype wire
